// File: design/hwa_pkg.sv
`default_nettype none

package hwa_pkg;

    localparam int CFG_W       = 7;
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = 3;
    localparam int AVG_W       = 24;
    localparam int FRAC_W      = 8;
    localparam int OUT_TDATA_W = 24;

    localparam logic [CFG_W-1:0] WINDOW_RST = CFG_W'(8);
    localparam logic [CFG_W-1:0] SLIDE_RST  = CFG_W'(1);

    localparam logic [AVG_W-1:0] AVG_MAX = {1'b0, {(AVG_W-1){1'b1}}};
    localparam logic [AVG_W-1:0] AVG_MIN = {1'b1, {(AVG_W-1){1'b0}}};

    typedef logic t_reg_idx;
    localparam t_reg_idx REG_WINDOW_SIZE = 1'b0;
    localparam t_reg_idx REG_SLIDE_STEP  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH,
        ST_CHECK,
        ST_DIV,
        ST_EMIT,
        ST_DRD,
        ST_DSUB
    } t_state;

endpackage

`default_nettype wire

// File: design/hopping_window_average.sv
// Sequence: an accepted item passes ST_PUSH and ST_CHECK; one that gives no result then leaves
// the block ready, while one that gives a result goes on through the one-bit-per-cycle restoring
// divider (ST_DIV) and ST_EMIT, which waits for a free output register and then loads it. No new
// sample is taken until ST_IDLE again: at once after a result that ends the stream, and
// after slide drops for one that slides (ring read plus shared adder pass per dropped sample).
// Reset (synchronous, active low) empties the window and loads window 8, slide 1.
`default_nettype none

module hopping_window_average #(
    parameter int WINDOW_MAX   = 64,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,

    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [hwa_pkg::ADDR_W-1:0]            paddr,
    input  logic [hwa_pkg::DATA_W-1:0]            pwdata,
    output logic [hwa_pkg::DATA_W-1:0]            prdata,
    output logic                                  pready,

    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     s_axis_tdata,   // sample
    input  logic                                  s_axis_tlast,   // last_sample

    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [hwa_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,   // average
    output logic [0:0]                            m_axis_tuser    // partial_window
);

    import hwa_pkg::*;

    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W = SAMPLE_WIDTH + CNT_W;
    localparam int D_W   = SUM_W + FRAC_W + 1;
    localparam int BIT_W = $clog2(D_W + 1);
    localparam int EXT_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int QX_W  = (D_W > AVG_W + 1) ? D_W : AVG_W + 1;

    t_state                   r_state, n_state;
    logic [CFG_W-1:0]         r_cfg_window, r_cfg_slide;
    logic [SAMPLE_WIDTH-1:0]  r_sample, n_sample;
    logic                     r_last, n_last;
    logic [SUM_W-1:0]         r_sum, n_sum;
    logic [CNT_W-1:0]         r_fill, n_fill;
    logic [IDX_W-1:0]         r_oldest, n_oldest;
    logic                     r_full, n_full;
    logic                     r_neg, n_neg;
    logic [D_W-1:0]           r_dvd, n_dvd;
    logic [CNT_W-1:0]         r_rem, n_rem;
    logic [BIT_W-1:0]         r_bit_cnt, n_bit_cnt;
    logic [CNT_W-1:0]         r_drop_cnt, n_drop_cnt;
    logic                     r_m_valid, n_m_valid;
    logic [AVG_W-1:0]         r_m_avg, n_m_avg;
    logic                     r_m_partial, n_m_partial;
    logic [SAMPLE_WIDTH-1:0]  r_rd_data;
    logic [SAMPLE_WIDTH-1:0]  r_ring [WINDOW_MAX];

    logic [EXT_W-1:0]         ws_ext, slide_ext;
    logic [CNT_W-1:0]         ws, slide;
    logic [SUM_W-1:0]         sum_addend, sum_result;
    logic [CNT_W:0]           pos_ext;
    logic [IDX_W-1:0]         push_pos;
    logic                     ring_we;
    logic [CNT_W:0]           rem_shift;
    logic                     rem_ge;
    logic [QX_W-1:0]          q_ext;
    logic [AVG_W-1:0]         avg_sat;
    logic [SUM_W-1:0]         mag;
    logic                     cfg_we;

    // effective window and slide
    always_comb begin
        ws_ext = EXT_W'(r_cfg_window);
        if (r_cfg_window == '0) begin
            ws_ext = EXT_W'(1);
        end else if (ws_ext > EXT_W'(WINDOW_MAX)) begin
            ws_ext = EXT_W'(WINDOW_MAX);
        end
        ws = ws_ext[CNT_W-1:0];

        slide_ext = EXT_W'(r_cfg_slide);
        if (r_cfg_slide == '0) begin
            slide_ext = EXT_W'(1);
        end else if (slide_ext > EXT_W'(ws)) begin
            slide_ext = EXT_W'(ws);
        end
        slide = slide_ext[CNT_W-1:0];
    end

    // configuration port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_comb begin
        unique case (t_reg_idx'(paddr[2]))
            REG_WINDOW_SIZE: prdata = DATA_W'(r_cfg_window);
            REG_SLIDE_STEP:  prdata = DATA_W'(r_cfg_slide);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_window <= WINDOW_RST;
            r_cfg_slide  <= SLIDE_RST;
        end else if (cfg_we) begin
            unique case (t_reg_idx'(paddr[2]))
                REG_WINDOW_SIZE: r_cfg_window <= pwdata[CFG_W-1:0];
                REG_SLIDE_STEP:  r_cfg_slide  <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // shared sum adder: add the new sample, subtract a dropped one
    always_comb begin
        if (r_state == ST_DSUB) begin
            sum_addend = -{{(SUM_W-SAMPLE_WIDTH){r_rd_data[SAMPLE_WIDTH-1]}}, r_rd_data};
        end else begin
            sum_addend = {{(SUM_W-SAMPLE_WIDTH){r_sample[SAMPLE_WIDTH-1]}}, r_sample};
        end
        sum_result = r_sum + sum_addend;
    end

    // write position wraps around the ring
    always_comb begin
        pos_ext = (CNT_W+1)'(r_oldest) + (CNT_W+1)'(r_fill);
        if (pos_ext >= (CNT_W+1)'(WINDOW_MAX)) begin
            pos_ext = pos_ext - (CNT_W+1)'(WINDOW_MAX);
        end
        push_pos = pos_ext[IDX_W-1:0];
    end

    // divider step and output saturation
    assign rem_shift = {r_rem, r_dvd[D_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, ws};
    assign q_ext     = QX_W'(r_dvd);
    assign mag       = r_sum[SUM_W-1] ? -r_sum : r_sum;

    always_comb begin
        if (!r_neg) begin
            avg_sat = (q_ext > QX_W'(AVG_MAX)) ? AVG_MAX : q_ext[AVG_W-1:0];
        end else begin
            avg_sat = (q_ext > QX_W'(AVG_MAX) + QX_W'(1)) ? AVG_MIN : -q_ext[AVG_W-1:0];
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_sample    = r_sample;
        n_last      = r_last;
        n_sum       = r_sum;
        n_fill      = r_fill;
        n_oldest    = r_oldest;
        n_full      = r_full;
        n_neg       = r_neg;
        n_dvd       = r_dvd;
        n_rem       = r_rem;
        n_bit_cnt   = r_bit_cnt;
        n_drop_cnt  = r_drop_cnt;
        n_m_valid   = r_m_valid;
        n_m_avg     = r_m_avg;
        n_m_partial = r_m_partial;
        ring_we     = 1'b0;

        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_sample = s_axis_tdata[SAMPLE_WIDTH-1:0];
                    n_last   = s_axis_tlast;
                    n_state  = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (r_fill < CNT_W'(WINDOW_MAX)) begin
                    ring_we = 1'b1;
                    n_sum   = sum_result;
                    n_fill  = r_fill + CNT_W'(1);
                end
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                n_full    = r_fill >= ws;
                n_neg     = r_sum[SUM_W-1];
                n_dvd     = {1'b0, mag, {FRAC_W{1'b0}}} + D_W'(ws >> 1);
                n_rem     = '0;
                n_bit_cnt = BIT_W'(D_W);
                if ((r_fill >= ws) || r_last) begin
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_DIV: begin
                n_rem     = rem_ge ? CNT_W'(rem_shift - {1'b0, ws}) : rem_shift[CNT_W-1:0];
                n_dvd     = {r_dvd[D_W-2:0], rem_ge};
                n_bit_cnt = r_bit_cnt - BIT_W'(1);
                if (r_bit_cnt == BIT_W'(1)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // hold until the output register is free
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid   = 1'b1;
                    n_m_avg     = avg_sat;
                    n_m_partial = !r_full;
                    if (r_full && !r_last) begin
                        n_drop_cnt = slide;
                        n_state    = ST_DRD;
                    end else begin
                        n_sum    = '0;
                        n_fill   = '0;
                        n_oldest = '0;
                        n_state  = ST_IDLE;
                    end
                end
            end
            ST_DRD: begin
                // ring read of the oldest sample lands next cycle
                n_state = ST_DSUB;
            end
            ST_DSUB: begin
                n_sum      = sum_result;
                n_fill     = r_fill - CNT_W'(1);
                n_oldest   = (r_oldest == IDX_W'(WINDOW_MAX - 1)) ? '0 : r_oldest + IDX_W'(1);
                n_drop_cnt = r_drop_cnt - CNT_W'(1);
                n_state    = (r_drop_cnt == CNT_W'(1)) ? ST_IDLE : ST_DRD;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_sum     <= '0;
            r_fill    <= '0;
            r_oldest  <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_sum     <= n_sum;
            r_fill    <= n_fill;
            r_oldest  <= n_oldest;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample    <= n_sample;
        r_last      <= n_last;
        r_full      <= n_full;
        r_neg       <= n_neg;
        r_dvd       <= n_dvd;
        r_rem       <= n_rem;
        r_bit_cnt   <= n_bit_cnt;
        r_drop_cnt  <= n_drop_cnt;
        r_m_avg     <= n_m_avg;
        r_m_partial <= n_m_partial;
    end

    // sample ring
    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring[push_pos] <= r_sample;
        end
        r_rd_data <= r_ring[r_oldest];
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_m_avg);
    assign m_axis_tuser  = r_m_partial;

endmodule

`default_nettype wire
